@@ hdl/gbnr_pkg.sv @@
// Shared types and constants for the go-back-N receiver core.
// Depends on nothing; every other file imports it.
package gbnr_pkg;

    localparam int SEQ_BITS_DEF   = 16;
    localparam int TIMER_BITS_DEF = 24;
    localparam int FIELD_W        = 16;
    localparam int CFG_TIMER_W    = 24;
    localparam int APB_ADDR_W     = 4;
    localparam int APB_DATA_W     = 32;

    localparam logic [CFG_TIMER_W-1:0] RETRY_TICKS_RST = CFG_TIMER_W'(1000);
    localparam logic [CFG_TIMER_W-1:0] IDLE_TICKS_RST  = CFG_TIMER_W'(20000);
    localparam logic [FIELD_W-1:0]     LOCAL_ID_RST    = '0;

    typedef enum logic [1:0] {
        REG_RETRY_TICKS = 2'd0,
        REG_IDLE_TICKS  = 2'd1,
        REG_LOCAL_ID    = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        PH_LISTEN = 3'd0,
        PH_WOPEN  = 3'd1,
        PH_EST    = 3'd2,
        PH_WCLOSE = 3'd3,
        PH_CLOSED = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        K_SYN    = 3'd0,
        K_SYNACK = 3'd1,
        K_ACK    = 3'd2,
        K_DATA   = 3'd3,
        K_FIN    = 3'd4,
        K_FINACK = 3'd5
    } pkt_kind_t;

    typedef enum logic [2:0] {
        O_SYNACK = 3'd0,
        O_ACK    = 3'd1,
        O_DUP    = 3'd2,
        O_FINACK = 3'd3,
        O_OPEN   = 3'd4,
        O_CLOSE  = 3'd5,
        O_ABORT  = 3'd6
    } out_kind_t;

    typedef struct packed {
        logic [CFG_TIMER_W-1:0] retry_ticks;
        logic [CFG_TIMER_W-1:0] idle_ticks;
        logic [FIELD_W-1:0]     local_id;
    } cfg_t;

    typedef struct packed {
        logic               req_type;
        logic [2:0]         pkt_kind;
        logic [FIELD_W-1:0] pkt_seq;
        logic [FIELD_W-1:0] pkt_window;
        logic [FIELD_W-1:0] pkt_ident;
        logic               checksum_ok;
    } item_t;

    typedef struct packed {
        logic               valid;
        out_kind_t          out_kind;
        logic [FIELD_W-1:0] out_seq;
        logic [FIELD_W-1:0] out_ident;
        logic [FIELD_W-1:0] out_window;
        logic               deliver;
        logic [2:0]         link_phase;
    } result_t;

endpackage

@@ hdl/gbnr_in_if.sv @@
// Input channel carrying one received header or timer tick per beat.
// Depends on gbnr_pkg for the field widths.
interface gbnr_in_if import gbnr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [2:0]         pkt_kind;
    logic [FIELD_W-1:0] pkt_seq;
    logic [FIELD_W-1:0] pkt_window;
    logic [FIELD_W-1:0] pkt_ident;
    logic               checksum_ok;

    modport source (
        output valid, req_type, pkt_kind, pkt_seq, pkt_window, pkt_ident, checksum_ok,
        input  ready
    );
    modport sink (
        input  valid, req_type, pkt_kind, pkt_seq, pkt_window, pkt_ident, checksum_ok,
        output ready
    );
endinterface

@@ hdl/gbnr_out_if.sv @@
// Result channel carrying one packet to send or one link event per beat.
// Depends on gbnr_pkg for the field widths.
interface gbnr_out_if import gbnr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [2:0]         out_kind;
    logic [FIELD_W-1:0] out_seq;
    logic [FIELD_W-1:0] out_ident;
    logic [FIELD_W-1:0] out_window;
    logic               deliver;
    logic [2:0]         link_phase;

    modport source (
        output valid, out_kind, out_seq, out_ident, out_window, deliver, link_phase,
        input  ready
    );
    modport sink (
        input  valid, out_kind, out_seq, out_ident, out_window, deliver, link_phase,
        output ready
    );
endinterface

@@ hdl/gbnr_regs.sv @@
// APB configuration registers: retry ticks, idle ticks and local identifier.
// Depends on gbnr_pkg for register indexes and reset values.
module gbnr_regs import gbnr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_RETRY_TICKS: cfg_next.retry_ticks = pwdata[CFG_TIMER_W-1:0];
                REG_IDLE_TICKS:  cfg_next.idle_ticks  = pwdata[CFG_TIMER_W-1:0];
                REG_LOCAL_ID:    cfg_next.local_id    = pwdata[FIELD_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_RETRY_TICKS: prdata = APB_DATA_W'(cfg_reg.retry_ticks);
            REG_IDLE_TICKS:  prdata = APB_DATA_W'(cfg_reg.idle_ticks);
            REG_LOCAL_ID:    prdata = APB_DATA_W'(cfg_reg.local_id);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.retry_ticks <= RETRY_TICKS_RST;
            cfg_reg.idle_ticks  <= IDLE_TICKS_RST;
            cfg_reg.local_id    <= LOCAL_ID_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hdl/gbnr_engine.sv @@
// Link state machine: handshake, in-order data acknowledgement and tick timers.
// Depends on gbnr_pkg for phase, packet and result types.
module gbnr_engine import gbnr_pkg::*;
#(
    parameter int SEQ_BITS   = SEQ_BITS_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    localparam int CMP_W = (TIMER_BITS > CFG_TIMER_W) ? TIMER_BITS : CFG_TIMER_W;
    localparam logic [TIMER_BITS-1:0] TMR_MAX = '1;

    phase_t                phase_reg, phase_next;
    logic [SEQ_BITS-1:0]   hs_reg, hs_next;
    logic [SEQ_BITS-1:0]   exp_reg, exp_next;
    logic [FIELD_W-1:0]    window_reg, window_next;
    logic [SEQ_BITS-1:0]   last_seq_reg, last_seq_next;
    logic [FIELD_W-1:0]    last_ident_reg, last_ident_next;
    logic                  ack_valid_reg, ack_valid_next;
    logic [TIMER_BITS-1:0] tick_reg, tick_next;

    logic [SEQ_BITS-1:0]    seq_in;
    logic [SEQ_BITS-1:0]    hs_inc;
    logic [TIMER_BITS-1:0]  tick_inc;
    logic [CFG_TIMER_W-1:0] limit;
    logic                   is_tick;
    logic                   is_pkt;
    logic                   fire;
    logic                   syn_any;
    logic                   syn_hit;
    logic                   ack_hit;
    logic                   data_hit;
    logic                   fin_hit;

    assign seq_in   = SEQ_BITS'(item.pkt_seq);
    assign hs_inc   = hs_reg + SEQ_BITS'(1);
    assign tick_inc = (tick_reg != TMR_MAX) ? tick_reg + TIMER_BITS'(1) : tick_reg;
    assign limit    = (phase_reg == PH_EST) ? cfg.idle_ticks : cfg.retry_ticks;
    assign fire     = (CMP_W'(tick_inc) >= CMP_W'(limit)) || (tick_inc == TMR_MAX);
    assign is_tick  = item.req_type;
    assign is_pkt   = !item.req_type;
    assign syn_any  = is_pkt && (item.pkt_kind == K_SYN);
    assign syn_hit  = syn_any && item.checksum_ok && (seq_in == hs_reg);
    assign ack_hit  = is_pkt && (item.pkt_kind == K_ACK) && item.checksum_ok
                      && (seq_in == hs_inc);
    assign data_hit = (item.pkt_kind == K_DATA) && item.checksum_ok && (seq_in == exp_reg);
    assign fin_hit  = (item.pkt_kind == K_FIN) && item.checksum_ok && (seq_in == '0);

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_LISTEN, PH_CLOSED:
            begin
                if (syn_hit)
                    phase_next = PH_WOPEN;
            end
            PH_WOPEN:
            begin
                if (ack_hit)
                    phase_next = PH_EST;
            end
            PH_EST:
            begin
                if (is_tick && fire)
                    phase_next = PH_LISTEN;
                else if (is_pkt && !data_hit && fin_hit)
                    phase_next = PH_WCLOSE;
            end
            PH_WCLOSE:
            begin
                if (ack_hit)
                    phase_next = PH_CLOSED;
            end
            default:
            begin
                phase_next = PH_LISTEN;
            end
        endcase
    end

    always_comb
    begin
        hs_next         = hs_reg;
        exp_next        = exp_reg;
        window_next     = window_reg;
        last_seq_next   = last_seq_reg;
        last_ident_next = last_ident_reg;
        ack_valid_next  = ack_valid_reg;
        tick_next       = tick_reg;
        case (phase_reg)
            PH_LISTEN, PH_CLOSED:
            begin
                if (syn_hit)
                begin
                    window_next = item.pkt_window;
                    tick_next   = '0;
                end
            end
            PH_WOPEN:
            begin
                if (is_tick)
                    tick_next = fire ? '0 : tick_inc;
                else if (ack_hit)
                begin
                    hs_next        = hs_inc;
                    exp_next       = '0;
                    ack_valid_next = 1'b0;
                    tick_next      = '0;
                end
                else if (syn_any)
                    tick_next = '0;
            end
            PH_EST:
            begin
                if (is_tick)
                begin
                    if (fire)
                    begin
                        hs_next        = '0;
                        exp_next       = '0;
                        window_next    = '0;
                        ack_valid_next = 1'b0;
                        tick_next      = '0;
                    end
                    else
                        tick_next = tick_inc;
                end
                else
                begin
                    tick_next = '0;
                    if (data_hit)
                    begin
                        last_seq_next   = exp_reg;
                        last_ident_next = item.pkt_ident;
                        ack_valid_next  = 1'b1;
                        exp_next        = exp_reg + SEQ_BITS'(1);
                    end
                    else if (fin_hit)
                        hs_next = '0;
                end
            end
            PH_WCLOSE:
            begin
                if (is_tick)
                    tick_next = fire ? '0 : tick_inc;
                else if (ack_hit)
                begin
                    hs_next        = '0;
                    exp_next       = '0;
                    window_next    = '0;
                    ack_valid_next = 1'b0;
                    tick_next      = '0;
                end
            end
            default:
            begin
                hs_next        = '0;
                exp_next       = '0;
                window_next    = '0;
                ack_valid_next = 1'b0;
                tick_next      = '0;
            end
        endcase
    end

    always_comb
    begin
        res            = '0;
        res.out_kind   = O_SYNACK;
        res.link_phase = phase_next;
        res.out_window = window_reg;
        res.out_ident  = cfg.local_id;
        case (phase_reg)
            PH_LISTEN, PH_CLOSED:
            begin
                if (syn_hit)
                begin
                    res.valid      = 1'b1;
                    res.out_kind   = O_SYNACK;
                    res.out_seq    = FIELD_W'(hs_reg);
                    res.out_window = item.pkt_window;
                end
            end
            PH_WOPEN:
            begin
                if (is_tick)
                begin
                    if (fire)
                    begin
                        res.valid    = 1'b1;
                        res.out_kind = O_SYNACK;
                        res.out_seq  = FIELD_W'(hs_reg);
                    end
                end
                else if (ack_hit)
                begin
                    res.valid    = 1'b1;
                    res.out_kind = O_OPEN;
                    res.out_seq  = FIELD_W'(hs_inc);
                end
                else if (syn_any)
                begin
                    res.valid    = 1'b1;
                    res.out_kind = O_SYNACK;
                    res.out_seq  = FIELD_W'(hs_reg);
                end
            end
            PH_EST:
            begin
                if (is_tick)
                begin
                    if (fire)
                    begin
                        res.valid    = 1'b1;
                        res.out_kind = O_ABORT;
                        res.out_seq  = FIELD_W'(exp_reg);
                    end
                end
                else if (data_hit)
                begin
                    res.valid     = 1'b1;
                    res.out_kind  = O_ACK;
                    res.out_seq   = FIELD_W'(exp_reg);
                    res.out_ident = item.pkt_ident;
                    res.deliver   = 1'b1;
                end
                else if (fin_hit)
                begin
                    res.valid    = 1'b1;
                    res.out_kind = O_FINACK;
                    res.out_seq  = '0;
                end
                else if (ack_valid_reg)
                begin
                    res.valid     = 1'b1;
                    res.out_kind  = O_DUP;
                    res.out_seq   = FIELD_W'(last_seq_reg);
                    res.out_ident = last_ident_reg;
                end
            end
            PH_WCLOSE:
            begin
                if (is_tick)
                begin
                    if (fire)
                    begin
                        res.valid    = 1'b1;
                        res.out_kind = O_FINACK;
                        res.out_seq  = FIELD_W'(hs_reg);
                    end
                end
                else if (ack_hit)
                begin
                    res.valid    = 1'b1;
                    res.out_kind = O_CLOSE;
                    res.out_seq  = FIELD_W'(hs_inc);
                end
            end
            default:
            begin
                res.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LISTEN;
            hs_reg         <= '0;
            exp_reg        <= '0;
            window_reg     <= '0;
            last_seq_reg   <= '0;
            last_ident_reg <= '0;
            ack_valid_reg  <= 1'b0;
            tick_reg       <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            hs_reg         <= hs_next;
            exp_reg        <= exp_next;
            window_reg     <= window_next;
            last_seq_reg   <= last_seq_next;
            last_ident_reg <= last_ident_next;
            ack_valid_reg  <= ack_valid_next;
            tick_reg       <= tick_next;
        end
    end

endmodule

@@ hdl/go_back_n_receiver_core.sv @@
// Top level of the go-back-N receiver core: input register, link engine, result register.
// Depends on gbnr_pkg, gbnr_in_if, gbnr_out_if, gbnr_regs and gbnr_engine.
//
// pkt_in carries one received packet header (with its checksum verdict) or one
// timer tick per beat. res_out carries at most one result per input beat: a
// packet to send (SYNACK, ACK, duplicate ACK, FINACK) or a link event (opened,
// closed, idle abort), together with the link phase after that input.
// An accepted beat lands in the input register; the combinational engine works on it, and
// any result is registered in the result register once that register is empty or being
// taken. The result then stays valid on res_out until it is taken.
// Throughput: one beat per cycle while res_out does not stall; the engine update between
// the input register and the result register is combinational.
// When res_out stalls, the held result waits in the result register and one
// more beat is taken into the input register; pkt_in.ready then drops until the
// result is taken. Inputs that cause no result still wait for that slot.
// Reset clears the link to listening, all counters and sequence state, and the
// configuration registers to 1000 retry ticks, 20000 idle ticks and local id 0.
// Users write APB configuration only while the core is idle; the core does not check it.
module go_back_n_receiver_core import gbnr_pkg::*;
#(
    parameter int SEQ_BITS   = SEQ_BITS_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    gbnr_in_if.sink               pkt_in,
    gbnr_out_if.source            res_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t    cfg;
    item_t   s1_item_reg;
    logic    s1_valid_reg;
    result_t res;
    result_t out_reg;
    logic    out_valid_reg;
    logic    step;
    logic    in_fire;

    gbnr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gbnr_engine #(
        .SEQ_BITS   (SEQ_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (s1_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign step         = s1_valid_reg && (!out_valid_reg || res_out.ready);
    assign pkt_in.ready = !s1_valid_reg || step;
    assign in_fire      = pkt_in.valid && pkt_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pkt_in.ready)
                s1_valid_reg <= pkt_in.valid;
            if (step)
                out_valid_reg <= res.valid;
            else if (res_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.req_type    <= pkt_in.req_type;
            s1_item_reg.pkt_kind    <= pkt_in.pkt_kind;
            s1_item_reg.pkt_seq     <= pkt_in.pkt_seq;
            s1_item_reg.pkt_window  <= pkt_in.pkt_window;
            s1_item_reg.pkt_ident   <= pkt_in.pkt_ident;
            s1_item_reg.checksum_ok <= pkt_in.checksum_ok;
        end
        if (step && res.valid)
            out_reg <= res;
    end

    assign res_out.valid      = out_valid_reg;
    assign res_out.out_kind   = out_reg.out_kind;
    assign res_out.out_seq    = out_reg.out_seq;
    assign res_out.out_ident  = out_reg.out_ident;
    assign res_out.out_window = out_reg.out_window;
    assign res_out.deliver    = out_reg.deliver;
    assign res_out.link_phase = out_reg.link_phase;

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("Accepted beat did not reach the input register.");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !res_out.ready) |-> !pkt_in.ready)
        else $error("Input taken while both stages are full and stalled.");

    a_result_taken: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(res_out.ready))
        else $error("Result dropped without being taken.");

    a_deliver_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.deliver) |=> (out_valid_reg && res_out.out_kind == O_ACK))
        else $error("Delivery flagged on a result that is not a new-data ACK.");

endmodule

@@ tb/sv/gbnr_link_monitor.sv @@
`timescale 1ns / 100ps
// Monitor for the go-back-N receiver core: tracks the link state from accepted input beats
// and register writes, queues the replies the core must send and compares every result beat.
// Depends on gbnr_pkg and the gbnr_in_if and gbnr_out_if interfaces.
module gbnr_link_monitor import gbnr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    gbnr_in_if                    pkt_mon,
    gbnr_out_if                   res_mon,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    errors,
    output int                    pending,
    output int                    replies_checked,
    output logic [6:0]            kinds_seen
);

    localparam logic [CFG_TIMER_W-1:0] TICK_MAX = {CFG_TIMER_W{1'b1}};

    logic [CFG_TIMER_W-1:0] retry_lim;
    logic [CFG_TIMER_W-1:0] idle_lim;
    logic [FIELD_W-1:0]     lid;

    phase_t                 ph;
    logic [FIELD_W-1:0]     hs_seq;
    logic [FIELD_W-1:0]     rx_seq;
    logic [FIELD_W-1:0]     peer_win;
    logic [FIELD_W-1:0]     ack_seq;
    logic [FIELD_W-1:0]     ack_ident;
    logic                   ack_valid;
    logic [CFG_TIMER_W-1:0] tick_cnt;

    result_t                replies_due[$];
    item_t                  beat_in;
    result_t                reply;
    result_t                want;

    function automatic void drop_session();
        hs_seq    = '0;
        rx_seq    = '0;
        peer_win  = '0;
        ack_valid = 1'b0;
        tick_cnt  = '0;
    endfunction

    function automatic bit timer_fires(input logic [CFG_TIMER_W-1:0] limit);
        if (tick_cnt != TICK_MAX)
            tick_cnt = tick_cnt + CFG_TIMER_W'(1);
        if (tick_cnt >= limit || tick_cnt == TICK_MAX)
        begin
            tick_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic result_t make_reply(input out_kind_t kind, input logic [FIELD_W-1:0] seq,
                                           input logic [FIELD_W-1:0] ident,
                                           input logic [FIELD_W-1:0] win, input logic dlv);
        result_t r;
        r            = '0;
        r.valid      = 1'b1;
        r.out_kind   = kind;
        r.out_seq    = seq;
        r.out_ident  = ident;
        r.out_window = win;
        r.deliver    = dlv;
        return r;
    endfunction

    function automatic bit next_reply(input item_t it, output result_t r);
        logic [FIELD_W-1:0] next_hs;
        bit                 hit;
        bit                 good;
        next_hs = hs_seq + FIELD_W'(1);
        good    = it.checksum_ok;
        hit     = 1'b0;
        r       = '0;
        if (it.req_type)
        begin
            case (ph)
                PH_WOPEN:
                    if (timer_fires(retry_lim))
                    begin
                        r   = make_reply(O_SYNACK, hs_seq, lid, peer_win, 1'b0);
                        hit = 1'b1;
                    end
                PH_WCLOSE:
                    if (timer_fires(retry_lim))
                    begin
                        r   = make_reply(O_FINACK, hs_seq, lid, peer_win, 1'b0);
                        hit = 1'b1;
                    end
                PH_EST:
                    if (timer_fires(idle_lim))
                    begin
                        r   = make_reply(O_ABORT, rx_seq, lid, peer_win, 1'b0);
                        hit = 1'b1;
                        ph  = PH_LISTEN;
                        drop_session();
                    end
                default:
                    ;
            endcase
        end
        else
        begin
            case (ph)
                PH_LISTEN, PH_CLOSED:
                    if (it.pkt_kind == K_SYN && good && it.pkt_seq == hs_seq)
                    begin
                        peer_win = it.pkt_window;
                        ph       = PH_WOPEN;
                        tick_cnt = '0;
                        r        = make_reply(O_SYNACK, hs_seq, lid, peer_win, 1'b0);
                        hit      = 1'b1;
                    end
                PH_WOPEN:
                    if (it.pkt_kind == K_ACK && good && it.pkt_seq == next_hs)
                    begin
                        hs_seq    = next_hs;
                        rx_seq    = '0;
                        ack_valid = 1'b0;
                        tick_cnt  = '0;
                        ph        = PH_EST;
                        r         = make_reply(O_OPEN, hs_seq, lid, peer_win, 1'b0);
                        hit       = 1'b1;
                    end
                    else if (it.pkt_kind == K_SYN)
                    begin
                        tick_cnt = '0;
                        r        = make_reply(O_SYNACK, hs_seq, lid, peer_win, 1'b0);
                        hit      = 1'b1;
                    end
                PH_EST:
                begin
                    tick_cnt = '0;
                    if (it.pkt_kind == K_DATA && good && it.pkt_seq == rx_seq)
                    begin
                        ack_seq   = rx_seq;
                        ack_ident = it.pkt_ident;
                        ack_valid = 1'b1;
                        rx_seq    = rx_seq + FIELD_W'(1);
                        r         = make_reply(O_ACK, ack_seq, ack_ident, peer_win, 1'b1);
                        hit       = 1'b1;
                    end
                    else if (it.pkt_kind == K_FIN && good && it.pkt_seq == '0)
                    begin
                        hs_seq = '0;
                        ph     = PH_WCLOSE;
                        r      = make_reply(O_FINACK, '0, lid, peer_win, 1'b0);
                        hit    = 1'b1;
                    end
                    else if (ack_valid)
                    begin
                        r   = make_reply(O_DUP, ack_seq, ack_ident, peer_win, 1'b0);
                        hit = 1'b1;
                    end
                end
                PH_WCLOSE:
                    if (it.pkt_kind == K_ACK && good && it.pkt_seq == next_hs)
                    begin
                        r   = make_reply(O_CLOSE, next_hs, lid, peer_win, 1'b0);
                        hit = 1'b1;
                        ph  = PH_CLOSED;
                        drop_session();
                    end
                default:
                    ;
            endcase
        end
        r.link_phase = ph;
        return hit;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_lim       = RETRY_TICKS_RST;
            idle_lim        = IDLE_TICKS_RST;
            lid             = LOCAL_ID_RST;
            ph              = PH_LISTEN;
            drop_session();
            ack_seq         = '0;
            ack_ident       = '0;
            replies_due.delete();
            errors          = 0;
            pending         = 0;
            replies_checked = 0;
            kinds_seen      = '0;
        end
        else
        begin
            if (res_mon.valid && res_mon.ready)
            begin
                replies_checked++;
                if (res_mon.out_kind <= 3'd6)
                    kinds_seen[res_mon.out_kind] = 1'b1;
                if (replies_due.size() == 0)
                begin
                    $error("result beat with no reply due: kind %0d seq %0d",
                           res_mon.out_kind, res_mon.out_seq);
                    errors++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    check_field("out_kind", 32'(want.out_kind), 32'(res_mon.out_kind));
                    check_field("out_seq", 32'(want.out_seq), 32'(res_mon.out_seq));
                    check_field("out_ident", 32'(want.out_ident), 32'(res_mon.out_ident));
                    check_field("out_window", 32'(want.out_window),
                                32'(res_mon.out_window));
                    check_field("deliver", 32'(want.deliver), 32'(res_mon.deliver));
                    check_field("link_phase", 32'(want.link_phase),
                                32'(res_mon.link_phase));
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_RETRY_TICKS: retry_lim = pwdata[CFG_TIMER_W-1:0];
                    REG_IDLE_TICKS:  idle_lim  = pwdata[CFG_TIMER_W-1:0];
                    REG_LOCAL_ID:    lid       = pwdata[FIELD_W-1:0];
                    default:         ;
                endcase
            end
            if (pkt_mon.valid && pkt_mon.ready)
            begin
                beat_in.req_type    = pkt_mon.req_type;
                beat_in.pkt_kind    = pkt_mon.pkt_kind;
                beat_in.pkt_seq     = pkt_mon.pkt_seq;
                beat_in.pkt_window  = pkt_mon.pkt_window;
                beat_in.pkt_ident   = pkt_mon.pkt_ident;
                beat_in.checksum_ok = pkt_mon.checksum_ok;
                if (next_reply(beat_in, reply))
                    replies_due.push_back(reply);
            end
            pending = replies_due.size();
        end
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Top of the go-back-N receiver testbench: clock, reset, register writes, header and tick
// beats with random gaps and result back-pressure, watchdog and verdict.
// Depends on gbnr_pkg, both channel interfaces, go_back_n_receiver_core and gbnr_link_monitor.
module tb import gbnr_pkg::*;
();

    localparam int               STALL_LIMIT  = 500;
    localparam int               PHASE_BEATS  = 125;
    localparam logic [2:0]       KIND_SPARE_A = 3'd6;
    localparam logic [2:0]       KIND_SPARE_B = 3'd7;
    localparam logic [FIELD_W-1:0] SEQ_TOP    = {FIELD_W{1'b1}};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    errors;
    int                    pending;
    int                    replies_checked;
    logic [6:0]            kinds_seen;

    bit                    calm;
    int                    beats_sent;
    int                    settings_used;
    int                    quiet_cycles;

    gbnr_in_if  pkt_bus ();
    gbnr_out_if res_bus ();

    go_back_n_receiver_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pkt_in  (pkt_bus),
        .res_out (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    gbnr_link_monitor monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .pkt_mon         (pkt_bus),
        .res_mon         (res_bus),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .errors          (errors),
        .pending         (pending),
        .replies_checked (replies_checked),
        .kinds_seen      (kinds_seen)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((pkt_bus.valid && pkt_bus.ready) || (res_bus.valid && res_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no beat accepted for %0d cycles.", quiet_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic int pause_len();
        if (calm)
            return 0;
        return $urandom_range(0, 11);
    endfunction

    task automatic send_beat(input item_t it);
        int gap;
        gap = pause_len();
        if (gap != 0)
        begin
            pkt_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pkt_bus.req_type    = it.req_type;
        pkt_bus.pkt_kind    = it.pkt_kind;
        pkt_bus.pkt_seq     = it.pkt_seq;
        pkt_bus.pkt_window  = it.pkt_window;
        pkt_bus.pkt_ident   = it.pkt_ident;
        pkt_bus.checksum_ok = it.checksum_ok;
        pkt_bus.valid       = 1'b1;
        do
            @(posedge clk);
        while (!pkt_bus.ready);
        @(negedge clk);
        beats_sent++;
    endtask

    task automatic send_pkt(input logic [2:0] kind, input logic [FIELD_W-1:0] seq,
                            input logic [FIELD_W-1:0] win, input logic [FIELD_W-1:0] ident,
                            input bit ok);
        item_t it;
        it.req_type    = 1'b0;
        it.pkt_kind    = kind;
        it.pkt_seq     = seq;
        it.pkt_window  = win;
        it.pkt_ident   = ident;
        it.checksum_ok = ok;
        send_beat(it);
    endtask

    task automatic send_noise(input bit as_tick);
        item_t it;
        it.req_type    = as_tick ? 1'b1 : 1'($urandom_range(0, 1));
        it.pkt_kind    = 3'($urandom_range(0, 7));
        it.pkt_seq     = FIELD_W'($urandom());
        it.pkt_window  = FIELD_W'($urandom());
        it.pkt_ident   = FIELD_W'($urandom());
        it.checksum_ok = 1'($urandom_range(0, 1));
        send_beat(it);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_noise(1'b1);
    endtask

    task automatic settle();
        pkt_bus.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic apply_settings(input logic [CFG_TIMER_W-1:0] retry,
                                  input logic [CFG_TIMER_W-1:0] idle,
                                  input logic [FIELD_W-1:0] id);
        settle();
        reg_write(REG_RETRY_TICKS, APB_DATA_W'(retry));
        reg_write(REG_IDLE_TICKS, APB_DATA_W'(idle));
        reg_write(REG_LOCAL_ID, APB_DATA_W'(id));
        settings_used++;
    endtask

    task automatic run_directed();
        send_ticks(1);
        send_pkt(K_SYN, '0, 16'h1234, 16'h0001, 1'b0);
        send_pkt(K_SYN, SEQ_TOP, 16'h1234, 16'h0001, 1'b1);
        send_pkt(K_SYN, '0, SEQ_TOP, 16'h0000, 1'b1);
        send_ticks(2);
        send_pkt(K_SYN, '0, 16'h0000, 16'h0000, 1'b0);
        send_pkt(K_ACK, 16'd2, 16'h0000, 16'h0000, 1'b1);
        send_pkt(K_ACK, 16'd1, 16'h0000, 16'h0000, 1'b1);
        send_pkt(K_DATA, '0, 16'h0000, 16'h5555, 1'b0);
        send_pkt(KIND_SPARE_B, '0, 16'h0000, 16'h0000, 1'b1);
        send_pkt(K_DATA, '0, 16'h0000, SEQ_TOP, 1'b1);
        send_pkt(K_DATA, '0, 16'h0000, 16'h0000, 1'b1);
        send_pkt(K_DATA, 16'd1, SEQ_TOP, 16'h0000, 1'b1);
        send_pkt(KIND_SPARE_A, SEQ_TOP, SEQ_TOP, SEQ_TOP, 1'b1);
        send_pkt(K_FIN, 16'd1, 16'h0000, 16'h0000, 1'b1);
        send_pkt(K_FIN, '0, 16'h0000, 16'h0000, 1'b1);
        send_ticks(2);
        send_pkt(K_ACK, 16'd1, 16'h0000, 16'h0000, 1'b1);
        send_pkt(K_SYN, '0, 16'h0000, 16'h0000, 1'b1);
        send_pkt(K_ACK, 16'd1, 16'h0000, 16'h0000, 1'b1);
        send_ticks(4);
    endtask

    task automatic run_traffic(input int budget);
        int                 target;
        int                 n;
        int                 roll;
        int                 sessions;
        logic [FIELD_W-1:0] ds;
        target   = beats_sent + budget;
        sessions = 0;
        while (beats_sent < target)
        begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 15)
            begin
                repeat ($urandom_range(1, 4)) send_noise(1'b0);
                target += 2;
            end
            else
            begin
                sessions++;
                send_pkt(K_SYN, '0, FIELD_W'($urandom()), FIELD_W'($urandom()), 1'b1);
                if ($urandom_range(0, 4) == 0)
                    send_ticks($urandom_range(1, 4));
                if ($urandom_range(0, 5) == 0)
                    send_pkt(K_SYN, FIELD_W'($urandom()), FIELD_W'($urandom()),
                             FIELD_W'($urandom()), 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 7) == 0)
                    send_pkt(K_ACK, FIELD_W'($urandom()), FIELD_W'($urandom()),
                             FIELD_W'($urandom()), 1'($urandom_range(0, 1)));
                send_pkt(K_ACK, 16'd1, FIELD_W'($urandom()), FIELD_W'($urandom()), 1'b1);
                if (sessions == 1)
                    settle();
                ds = '0;
                n  = $urandom_range(3, 30);
                repeat (n)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 8)
                        send_ticks($urandom_range(1, 6));
                    else if (roll < 12)
                        send_pkt(K_DATA, ds, FIELD_W'($urandom()), FIELD_W'($urandom()), 1'b0);
                    else if (roll < 16)
                        send_pkt(K_DATA, ds - FIELD_W'(1), FIELD_W'($urandom()),
                                 FIELD_W'($urandom()), 1'b1);
                    else if (roll < 20)
                        send_pkt(3'($urandom_range(0, 7)), FIELD_W'($urandom()),
                                 FIELD_W'($urandom()), FIELD_W'($urandom()),
                                 1'($urandom_range(0, 1)));
                    else
                    begin
                        send_pkt(K_DATA, ds, FIELD_W'($urandom()), FIELD_W'($urandom()), 1'b1);
                        ds = ds + FIELD_W'(1);
                    end
                end
                if ($urandom_range(0, 9) == 0)
                    send_pkt(K_FIN, FIELD_W'($urandom()), FIELD_W'($urandom()),
                             FIELD_W'($urandom()), 1'($urandom_range(0, 1)));
                send_pkt(K_FIN, '0, FIELD_W'($urandom()), FIELD_W'($urandom()), 1'b1);
                if ($urandom_range(0, 3) == 0)
                    send_ticks($urandom_range(1, 5));
                if ($urandom_range(0, 9) == 0)
                    send_pkt(K_ACK, 16'd2, FIELD_W'($urandom()), FIELD_W'($urandom()), 1'b1);
                send_pkt(K_ACK, 16'd1, FIELD_W'($urandom()), FIELD_W'($urandom()), 1'b1);
            end
        end
    endtask

    initial
    begin
        int stall;
        res_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = pause_len();
            if (stall != 0)
            begin
                res_bus.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_bus.ready = 1'b1;
            do
                @(posedge clk);
            while (!res_bus.valid);
            @(negedge clk);
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        pkt_bus.valid       = 1'b0;
        pkt_bus.req_type    = 1'b0;
        pkt_bus.pkt_kind    = '0;
        pkt_bus.pkt_seq     = '0;
        pkt_bus.pkt_window  = '0;
        pkt_bus.pkt_ident   = '0;
        pkt_bus.checksum_ok = 1'b0;
        calm                = 1'b0;
        beats_sent          = 0;
        settings_used       = 0;
        quiet_cycles        = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        apply_settings(24'd2, 24'd4, 16'hA5C3);
        run_directed();

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0:       apply_settings(24'd1, 24'd1, 16'h0000);
                1:       apply_settings(24'd0, 24'd0, SEQ_TOP);
                2:       apply_settings({CFG_TIMER_W{1'b1}}, {CFG_TIMER_W{1'b1}},
                                        FIELD_W'($urandom()));
                3:       apply_settings(CFG_TIMER_W'($urandom_range(1, 8)),
                                        CFG_TIMER_W'($urandom_range(2, 10)),
                                        FIELD_W'($urandom()));
                default: apply_settings(24'd3, 24'd6, FIELD_W'($urandom()));
            endcase
            run_traffic(PHASE_BEATS);
        end

        calm = 1'b0;
        settle();
        $display("Sent %0d header and tick beats under %0d register settings.",
                 beats_sent, settings_used);
        $display("Checked %0d result beats, %0d of 7 result kinds seen.",
                 replies_checked, $countones(kinds_seen));
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/gbnr_pkg.sv
hdl/gbnr_in_if.sv
hdl/gbnr_out_if.sv
hdl/gbnr_regs.sv
hdl/gbnr_engine.sv
hdl/go_back_n_receiver_core.sv
tb/sv/gbnr_link_monitor.sv
tb/sv/tb.sv
